[design/mwee_pkg.sv]
// Package for the Microwire EEPROM master: command codes, engine modes,
// frame constants and the result beat layout.
// No dependencies.
package mwee_pkg;

  localparam int DATA_BITS     = 16;
  localparam int MAX_ADDR_BITS = 8;
  localparam int FRAME_W       = 28;

  // tdata of the input channel, padded to whole bytes
  localparam int IN_W  = 32;
  // tdata of the result channel, padded to whole bytes
  localparam int OUT_W = 24;

  localparam logic [3:0]  ADDR_BITS_RESET  = 4'd6;
  localparam logic [13:0] POLL_LIMIT_RESET = 14'd10000;
  localparam logic [13:0] POLL_SAT         = 14'h3fff;

  localparam logic [10:0] OP_READ_HDR  = 11'd6;
  localparam logic [10:0] OP_WRITE_HDR = 11'd5;
  localparam logic [10:0] EWEN_PATTERN = 11'h4f;
  localparam logic [10:0] EWDS_PATTERN = 11'h40;

  typedef enum logic [2:0] {
    CMD_READ  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_EWEN  = 3'd2,
    CMD_EWDS  = 3'd3,
    CMD_WAIT  = 3'd4,
    CMD_TICK  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_FRAME = 2'd1,
    MODE_WAIT  = 2'd2
  } mode_t;

  typedef enum logic {
    REG_ADDR_BITS  = 1'b0,
    REG_POLL_LIMIT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic        last;
    logic        timed_out;
    logic        finished;
    logic [15:0] read_value;
    logic        data_in_pin;
    logic        shift_clock;
    logic        chip_select;
  } res_t;

endpackage

[design/microwire_eeprom_master.sv]
// Top level of the Microwire EEPROM master: input register, command engine,
// four-entry result buffer and APB register port.
// Depends on mwee_pkg.

// Each accepted beat is held in an input register, then the engine turns it
// combinationally into zero to four pin-state beats, loaded into a small
// result buffer that drains one beat per cycle while out_tready is high. A
// new input beat is taken every cycle as long as each item yields at most
// one result and out_tready stays high; a frame tick yields two beats (four
// on the final bit), so then the result port sets the pace at one beat per
// cycle. There is no clearing pass after reset.
module microwire_eeprom_master (
  input  logic                       clk,
  input  logic                       rst_n,
  // in_tdata: command[2:0], address[10:3], write_data[26:11],
  // data_out_level[27], zero fill above
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [mwee_pkg::IN_W-1:0]  in_tdata,
  // out_tdata: chip_select[0], shift_clock[1], data_in_pin[2],
  // read_value[18:3], finished[19], timed_out[20], zero fill above
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [mwee_pkg::OUT_W-1:0] out_tdata,
  output logic                       out_tlast,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [2:0]                 cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import mwee_pkg::*;

  // configuration
  logic [3:0]  addr_bits_r;
  logic [13:0] poll_limit_r;
  logic        cfg_wr;
  reg_idx_t    cfg_sel;

  // input register
  logic        inv_r;
  cmd_t        cmd_r;
  logic [7:0]  addr_r;
  logic [15:0] wdata_r;
  logic        level_r;

  // engine state
  mode_t       mode_r, mode_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [4:0]  bits_left_r, bits_left_nxt;
  logic [15:0] capture_r, capture_nxt;
  logic [13:0] poll_cnt_r, poll_cnt_nxt;

  // result buffer
  res_t        res_r [4];
  res_t        res_nxt [4];
  logic [2:0]  res_cnt_r, res_cnt_nxt;
  logic [1:0]  res_idx_r;
  logic [2:0]  n_res;

  logic        out_fire, buf_free, adv;

  // working values
  logic [3:0]  ab;
  logic [7:0]  amask;
  logic [7:0]  addr_m;
  logic [10:0] hdr;
  logic [4:0]  bl_m1;
  logic        bit_o;
  logic [13:0] limit;
  logic [13:0] poll_inc;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_sel    = reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    unique case (cfg_sel)
      REG_ADDR_BITS:  cfg_prdata = {28'd0, addr_bits_r};
      REG_POLL_LIMIT: cfg_prdata = {18'd0, poll_limit_r};
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_bits_r  <= ADDR_BITS_RESET;
      poll_limit_r <= POLL_LIMIT_RESET;
    end else if (cfg_wr) begin
      if (cfg_sel == REG_ADDR_BITS) addr_bits_r <= cfg_pwdata[3:0];
      else                          poll_limit_r <= cfg_pwdata[13:0];
    end
  end

  // ---------------- handshakes ----------------
  assign out_tvalid = (res_cnt_r != 3'd0);
  assign out_fire   = out_tvalid & out_tready;
  // buffer is free once empty or its last beat leaves now
  assign buf_free   = (res_cnt_r == 3'd0) ||
                      (out_fire && ({1'b0, res_idx_r} == res_cnt_r - 3'd1));
  assign adv        = buf_free;
  assign in_tready  = !inv_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (in_tready) begin
      inv_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r   <= cmd_t'(in_tdata[2:0]);
      addr_r  <= in_tdata[10:3];
      wdata_r <= in_tdata[26:11];
      level_r <= in_tdata[27];
    end
  end

  // ---------------- command engine ----------------
  always_comb begin
    priority if (addr_bits_r < 4'd4)                  ab = 4'd4;
    else if (addr_bits_r > 4'(MAX_ADDR_BITS))         ab = 4'(MAX_ADDR_BITS);
    else                                              ab = addr_bits_r;
  end

  assign amask    = 8'((9'd1 << ab) - 9'd1);
  assign addr_m   = addr_r & amask;
  assign bl_m1    = bits_left_r - 5'd1;
  assign bit_o    = frame_r[bl_m1];
  assign limit    = (poll_limit_r == 14'd0) ? 14'd1 : poll_limit_r;
  assign poll_inc = (poll_cnt_r < POLL_SAT) ? poll_cnt_r + 14'd1 : poll_cnt_r;

  always_comb begin
    mode_nxt      = mode_r;
    frame_nxt     = frame_r;
    bits_left_nxt = bits_left_r;
    capture_nxt   = capture_r;
    poll_cnt_nxt  = poll_cnt_r;
    n_res         = 3'd0;
    hdr           = '0;
    for (int i = 0; i < 4; i++) res_nxt[i] = '0;

    if (inv_r) begin
      unique case (cmd_r)
        CMD_READ, CMD_WRITE, CMD_EWEN, CMD_EWDS: begin
          if (mode_r == MODE_IDLE) begin
            unique case (cmd_r)
              CMD_READ: begin
                hdr           = (OP_READ_HDR << ab) | {3'd0, addr_m};
                frame_nxt     = {1'b0, hdr, 16'd0};
                bits_left_nxt = 5'd20 + {1'b0, ab};
              end
              CMD_WRITE: begin
                hdr           = (OP_WRITE_HDR << ab) | {3'd0, addr_m};
                frame_nxt     = {1'b0, hdr, wdata_r};
                bits_left_nxt = 5'd20 + {1'b0, ab};
              end
              CMD_EWEN: begin
                frame_nxt     = FRAME_W'(EWEN_PATTERN << (ab - 4'd4));
                bits_left_nxt = 5'd4 + {1'b0, ab};
              end
              default: begin
                frame_nxt     = FRAME_W'(EWDS_PATTERN << (ab - 4'd4));
                bits_left_nxt = 5'd4 + {1'b0, ab};
              end
            endcase
            capture_nxt             = '0;
            mode_nxt                = MODE_FRAME;
            n_res                   = 3'd1;
            res_nxt[0].chip_select  = 1'b1;
            res_nxt[0].shift_clock  = 1'b1;
            res_nxt[0].last         = 1'b1;
          end
        end
        CMD_WAIT: begin
          if (mode_r == MODE_IDLE) begin
            poll_cnt_nxt           = '0;
            mode_nxt               = MODE_WAIT;
            n_res                  = 3'd1;
            res_nxt[0].chip_select = 1'b1;
            res_nxt[0].last        = 1'b1;
          end
        end
        CMD_TICK: begin
          if (mode_r == MODE_FRAME) begin
            if (bits_left_r == 5'd0 || bits_left_r > 5'(FRAME_W)) begin
              // corrupt count: close the frame at once
              mode_nxt              = MODE_IDLE;
              bits_left_nxt         = '0;
              n_res                 = 3'd1;
              res_nxt[0].read_value = capture_r;
              res_nxt[0].finished   = 1'b1;
              res_nxt[0].last       = 1'b1;
            end else begin
              capture_nxt            = {capture_r[14:0], level_r};
              bits_left_nxt          = bl_m1;
              res_nxt[0].chip_select = 1'b1;
              res_nxt[0].data_in_pin = bit_o;
              res_nxt[1].chip_select = 1'b1;
              res_nxt[1].shift_clock = 1'b1;
              res_nxt[1].data_in_pin = bit_o;
              if (bl_m1 != 5'd0) begin
                n_res           = 3'd2;
                res_nxt[1].last = 1'b1;
              end else begin
                // final bit: idle beat, then deselect with the captured word
                mode_nxt               = MODE_IDLE;
                n_res                  = 3'd4;
                res_nxt[2].chip_select = 1'b1;
                res_nxt[3].read_value  = {capture_r[14:0], level_r};
                res_nxt[3].finished    = 1'b1;
                res_nxt[3].last        = 1'b1;
              end
            end
          end else if (mode_r == MODE_WAIT) begin
            n_res                  = 3'd1;
            res_nxt[0].chip_select = 1'b1;
            res_nxt[0].last        = 1'b1;
            if (level_r) begin
              mode_nxt            = MODE_IDLE;
              res_nxt[0].finished = 1'b1;
            end else begin
              poll_cnt_nxt = poll_inc;
              if (poll_inc >= limit) begin
                mode_nxt             = MODE_IDLE;
                res_nxt[0].finished  = 1'b1;
                res_nxt[0].timed_out = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      frame_r     <= '0;
      bits_left_r <= '0;
      capture_r   <= '0;
      poll_cnt_r  <= '0;
    end else if (adv) begin
      mode_r      <= mode_nxt;
      frame_r     <= frame_nxt;
      bits_left_r <= bits_left_nxt;
      capture_r   <= capture_nxt;
      poll_cnt_r  <= poll_cnt_nxt;
    end
  end

  // ---------------- result buffer ----------------
  assign res_cnt_nxt = adv ? n_res : res_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cnt_r <= '0;
      res_idx_r <= '0;
    end else begin
      res_cnt_r <= res_cnt_nxt;
      if (adv)           res_idx_r <= '0;
      else if (out_fire) res_idx_r <= res_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) res_r[i] <= res_nxt[i];
    end
  end

  assign out_tdata = {3'd0, res_r[res_idx_r].timed_out, res_r[res_idx_r].finished,
                      res_r[res_idx_r].read_value, res_r[res_idx_r].data_in_pin,
                      res_r[res_idx_r].shift_clock, res_r[res_idx_r].chip_select};
  assign out_tlast = res_r[res_idx_r].last;

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, res_idx_r} < res_cnt_r))
    else $error("result index beyond buffer fill");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= 3'd4)
    else $error("result buffer overfilled");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (inv_r && !adv) |-> !in_tready)
    else $error("input register overwritten while held");

  a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bits_left_r <= 5'(FRAME_W))
    else $error("frame bit count out of range");

  a_timeout_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_r[res_idx_r].timed_out) |->
      (res_r[res_idx_r].finished && res_r[res_idx_r].last))
    else $error("timeout beat not marked finished");
`endif

endmodule

[dv/microwire_eeprom_master_tb.sv]
// Self-checking testbench for the Microwire EEPROM master: directed rows, then
// constrained-by-hand random frames and ready-waits under stream back-pressure.
// Depends on mwee_pkg and microwire_eeprom_master.
module microwire_eeprom_master_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mwee_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int ITEMS_PER_SEG = 45;
  localparam int PREDICT       = -1;

  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  // {last, timed_out, finished, read_value, data_in_pin, shift_clock, chip_select}
  localparam res_t NO_BEAT      = '0;
  localparam res_t OPEN_BEAT    = {1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b1};
  localparam res_t POLL_BEAT    = {1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1};
  localparam res_t READY_BEAT   = {1'b1, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b1};
  localparam res_t TIMEOUT_BEAT = {1'b1, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b1};

  localparam logic [3:0]  SEG_ADDR_BITS  [6] = '{4'd4, 4'd8, 4'd5, 4'd7, 4'd6, 4'd15};
  localparam logic [13:0] SEG_POLL_LIMIT [6] = '{14'd1, 14'd16383, 14'd3, 14'd0, 14'd6, 14'd2};

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  addr;
    logic [15:0] wdata;
    logic        level;
  } in_item_t;

  typedef enum logic [1:0] {LVL_LOW, LVL_HIGH, LVL_ALT} lvl_t;
  typedef enum logic [1:0] {ROW_ITEM, ROW_SET_ADDR_BITS, ROW_SET_POLL_LIMIT} row_kind_t;

  // register rows carry the value in wdata; typed_n is the count of typed beats
  // (0 or 1) or PREDICT
  typedef struct {
    row_kind_t   kind;
    logic [2:0]  cmd;
    logic [7:0]  addr;
    logic [15:0] wdata;
    lvl_t        lvl;
    int          reps;
    int          typed_n;
    res_t        typed_beat;
  } plan_row_t;

  plan_row_t directed_plan [35] = '{
    '{ROW_ITEM, CMD_TICK,  8'h00, 16'h0000, LVL_LOW,  1,  0,       NO_BEAT},   // tick while idle
    '{ROW_ITEM, CMD_RSVD6, 8'h00, 16'h0000, LVL_LOW,  1,  0,       NO_BEAT},
    '{ROW_ITEM, CMD_RSVD7, 8'hff, 16'hffff, LVL_HIGH, 1,  0,       NO_BEAT},
    '{ROW_ITEM, CMD_EWEN,  8'h00, 16'h0000, LVL_LOW,  1,  1,       OPEN_BEAT},
    '{ROW_ITEM, CMD_READ,  8'hff, 16'h0000, LVL_LOW,  1,  0,       NO_BEAT},   // start while busy
    '{ROW_ITEM, CMD_WAIT,  8'h00, 16'h0000, LVL_HIGH, 1,  0,       NO_BEAT},
    '{ROW_ITEM, CMD_TICK,  8'h00, 16'h0000, LVL_LOW,  10, PREDICT, NO_BEAT},
    '{ROW_ITEM, CMD_WRITE, 8'hff, 16'hffff, LVL_LOW,  1,  1,       OPEN_BEAT}, // address masked
    '{ROW_ITEM, CMD_TICK,  8'h00, 16'h0000, LVL_HIGH, 26, PREDICT, NO_BEAT},
    '{ROW_ITEM, CMD_READ,  8'h00, 16'h0000, LVL_LOW,  1,  1,       OPEN_BEAT},
    '{ROW_ITEM, CMD_TICK,  8'h00, 16'h0000, LVL_ALT,  26, PREDICT, NO_BEAT},
    '{ROW_ITEM, CMD_EWDS,  8'h00, 16'h0000, LVL_LOW,  1,  1,       OPEN_BEAT},
    '{ROW_ITEM, CMD_TICK,  8'h00, 16'h0000, LVL_HIGH, 10, PREDICT, NO_BEAT},
    '{ROW_ITEM, CMD_WAIT,  8'h00, 16'h0000, LVL_LOW,  1,  1,       POLL_BEAT},
    '{ROW_ITEM, CMD_TICK,  8'h00, 16'h0000, LVL_LOW,  1,  1,       POLL_BEAT},
    '{ROW_ITEM, CMD_TICK,  8'h00, 16'h0000, LVL_HIGH, 1,  1,       READY_BEAT},
    '{ROW_SET_ADDR_BITS,  CMD_READ, 8'h00, 16'd4, LVL_LOW, 1, 0, NO_BEAT},
    '{ROW_ITEM, CMD_READ,  8'hff, 16'h0000, LVL_LOW,  1,  1,       OPEN_BEAT},
    '{ROW_ITEM, CMD_TICK,  8'h00, 16'h0000, LVL_ALT,  24, PREDICT, NO_BEAT},
    '{ROW_SET_ADDR_BITS,  CMD_READ, 8'h00, 16'd8, LVL_LOW, 1, 0, NO_BEAT},
    '{ROW_ITEM, CMD_WRITE, 8'ha5, 16'h5a3c, LVL_LOW,  1,  1,       OPEN_BEAT},
    '{ROW_ITEM, CMD_TICK,  8'h00, 16'h0000, LVL_LOW,  28, PREDICT, NO_BEAT},
    // out-of-range widths saturate to 8 and 4
    '{ROW_SET_ADDR_BITS,  CMD_READ, 8'h00, 16'd15, LVL_LOW, 1, 0, NO_BEAT},
    '{ROW_ITEM, CMD_EWEN,  8'h00, 16'h0000, LVL_LOW,  1,  1,       OPEN_BEAT},
    '{ROW_ITEM, CMD_TICK,  8'h00, 16'h0000, LVL_ALT,  12, PREDICT, NO_BEAT},
    '{ROW_SET_ADDR_BITS,  CMD_READ, 8'h00, 16'd0, LVL_LOW, 1, 0, NO_BEAT},
    '{ROW_ITEM, CMD_EWDS,  8'h00, 16'h0000, LVL_LOW,  1,  1,       OPEN_BEAT},
    '{ROW_ITEM, CMD_TICK,  8'h00, 16'h0000, LVL_HIGH, 8,  PREDICT, NO_BEAT},
    // a zero poll limit acts as one
    '{ROW_SET_POLL_LIMIT, CMD_READ, 8'h00, 16'd0, LVL_LOW, 1, 0, NO_BEAT},
    '{ROW_ITEM, CMD_WAIT,  8'h00, 16'h0000, LVL_LOW,  1,  1,       POLL_BEAT},
    '{ROW_ITEM, CMD_TICK,  8'h00, 16'h0000, LVL_LOW,  1,  1,       TIMEOUT_BEAT},
    '{ROW_SET_POLL_LIMIT, CMD_READ, 8'h00, 16'd16383, LVL_LOW, 1, 0, NO_BEAT},
    '{ROW_ITEM, CMD_WAIT,  8'h00, 16'h0000, LVL_LOW,  1,  1,       POLL_BEAT},
    '{ROW_ITEM, CMD_TICK,  8'h00, 16'h0000, LVL_LOW,  1,  1,       POLL_BEAT},
    '{ROW_ITEM, CMD_TICK,  8'h00, 16'h0000, LVL_HIGH, 1,  1,       READY_BEAT}
  };

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;    // command, address, write_data, data_out_level
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;   // chip_select, shift_clock, data_in_pin, read_value,
                                 // finished, timed_out
  logic             out_tlast;
  logic             cfg_psel;
  logic             cfg_penable;
  logic             cfg_pwrite;
  logic [2:0]       cfg_paddr;
  logic [31:0]      cfg_pwdata;
  logic [31:0]      cfg_prdata;
  logic             cfg_pready;

  // predictor state and register shadows
  logic [FRAME_W-1:0] mdl_frame;
  logic [4:0]         mdl_bits_left;
  logic [15:0]        mdl_capture;
  mode_t              mdl_mode;
  logic [13:0]        mdl_polls;
  logic [3:0]         addr_bits_shadow;
  logic [13:0]        poll_limit_shadow;

  res_t pin_beats_due[$];
  res_t step_beats[4];
  int   fail_count;
  int   send_idle_pct;
  int   recv_stall_pct;

  microwire_eeprom_master dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic res_t pin_beat(logic cs, logic sclk, logic di, logic [15:0] rv,
                                    logic fin, logic to, logic last);
    return {last, to, fin, rv, di, sclk, cs};
  endfunction

  // Advances the predicted engine by one accepted item; beats land in step_beats.
  function automatic int pin_model_step(in_item_t it);
    logic [3:0]  ab;
    logic [31:0] addr_m;
    logic [31:0] wide;
    logic [13:0] limit;
    logic        bit_out;
    ab = addr_bits_shadow;
    if (ab < 4) ab = 4'd4;
    if (ab > MAX_ADDR_BITS) ab = 4'(MAX_ADDR_BITS);
    if (it.cmd <= CMD_EWDS) begin
      if (mdl_mode != MODE_IDLE) return 0;
      addr_m = 32'(it.addr) & ((32'd1 << ab) - 32'd1);
      case (it.cmd)
        CMD_READ: begin
          wide = ((32'(OP_READ_HDR) << ab) | addr_m) << DATA_BITS;
          mdl_bits_left = 5'(4 + ab + DATA_BITS);
        end
        CMD_WRITE: begin
          wide = (((32'(OP_WRITE_HDR) << ab) | addr_m) << DATA_BITS) | 32'(it.wdata);
          mdl_bits_left = 5'(4 + ab + DATA_BITS);
        end
        CMD_EWEN: begin
          wide = 32'(EWEN_PATTERN) << (ab - 4'd4);
          mdl_bits_left = 5'(4 + ab);
        end
        default: begin
          wide = 32'(EWDS_PATTERN) << (ab - 4'd4);
          mdl_bits_left = 5'(4 + ab);
        end
      endcase
      mdl_frame = wide[FRAME_W-1:0];
      mdl_capture = '0;
      mdl_mode = MODE_FRAME;
      step_beats[0] = OPEN_BEAT;
      return 1;
    end
    if (it.cmd == CMD_WAIT) begin
      if (mdl_mode != MODE_IDLE) return 0;
      mdl_polls = '0;
      mdl_mode = MODE_WAIT;
      step_beats[0] = POLL_BEAT;
      return 1;
    end
    if (it.cmd != CMD_TICK) return 0;
    if (mdl_mode == MODE_FRAME) begin
      if (mdl_bits_left == 0 || mdl_bits_left > FRAME_W) begin
        mdl_mode = MODE_IDLE;
        mdl_bits_left = '0;
        step_beats[0] = pin_beat(1'b0, 1'b0, 1'b0, mdl_capture, 1'b1, 1'b0, 1'b1);
        return 1;
      end
      bit_out = mdl_frame[mdl_bits_left - 5'd1];
      mdl_capture = {mdl_capture[14:0], it.level};
      mdl_bits_left = mdl_bits_left - 5'd1;
      step_beats[0] = pin_beat(1'b1, 1'b0, bit_out, 16'h0, 1'b0, 1'b0, 1'b0);
      if (mdl_bits_left != 0) begin
        step_beats[1] = pin_beat(1'b1, 1'b1, bit_out, 16'h0, 1'b0, 1'b0, 1'b1);
        return 2;
      end
      // last bit: idle state, then deselect carrying the captured word
      mdl_mode = MODE_IDLE;
      step_beats[1] = pin_beat(1'b1, 1'b1, bit_out, 16'h0, 1'b0, 1'b0, 1'b0);
      step_beats[2] = pin_beat(1'b1, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b0);
      step_beats[3] = pin_beat(1'b0, 1'b0, 1'b0, mdl_capture, 1'b1, 1'b0, 1'b1);
      return 4;
    end
    if (mdl_mode == MODE_WAIT) begin
      limit = (poll_limit_shadow == 0) ? 14'd1 : poll_limit_shadow;
      if (it.level) begin
        mdl_mode = MODE_IDLE;
        step_beats[0] = READY_BEAT;
        return 1;
      end
      if (mdl_polls < POLL_SAT) mdl_polls = mdl_polls + 14'd1;
      if (mdl_polls >= limit) begin
        mdl_mode = MODE_IDLE;
        step_beats[0] = TIMEOUT_BEAT;
        return 1;
      end
      step_beats[0] = POLL_BEAT;
      return 1;
    end
    return 0;
  endfunction

  // Mostly well-formed traffic: starts when idle, ticks when busy, some noise.
  function automatic in_item_t pick_item();
    in_item_t it;
    int       roll;
    it.addr  = 8'($urandom);
    it.wdata = 16'($urandom);
    it.level = 1'($urandom);
    roll     = $urandom_range(99);
    if (mdl_mode == MODE_IDLE) begin
      if (roll < 10)      it.cmd = 3'($urandom_range(int'(CMD_RSVD7), int'(CMD_TICK)));
      else if (roll < 30) it.cmd = CMD_WAIT;
      else if (roll < 45) it.cmd = $urandom_range(1) ? CMD_EWEN : CMD_EWDS;
      else                it.cmd = $urandom_range(1) ? CMD_READ : CMD_WRITE;
    end else if (roll < 6) begin
      it.cmd = 3'($urandom);
    end else begin
      it.cmd = CMD_TICK;
      // ready comes back after a few polls so that timeouts also show up
      if (mdl_mode == MODE_WAIT) it.level = ($urandom_range(5) == 0);
    end
    return it;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tlast, out_tdata[20:0]};
      if (pin_beats_due.size() == 0) begin
        $error("result beat %0h with nothing expected", got);
        fail_count++;
      end else begin
        want = pin_beats_due.pop_front();
        check_field("chip_select", 32'(want.chip_select), 32'(got.chip_select));
        check_field("shift_clock", 32'(want.shift_clock), 32'(got.shift_clock));
        check_field("data_in_pin", 32'(want.data_in_pin), 32'(got.data_in_pin));
        check_field("read_value",  32'(want.read_value),  32'(got.read_value));
        check_field("finished",    32'(want.finished),    32'(got.finished));
        check_field("timed_out",   32'(want.timed_out),   32'(got.timed_out));
        check_field("last",        32'(want.last),        32'(got.last));
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Entered and left just after a falling edge.
  task automatic send_item(input in_item_t it, input int typed_n, input res_t typed_beat,
                           output int produced);
    int n;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {4'b0000, it.level, it.wdata, it.addr, it.cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n = pin_model_step(it);
    if (typed_n == PREDICT) begin
      for (int b = 0; b < n; b++) pin_beats_due.push_back(step_beats[b]);
    end else if (typed_n > 0) begin
      pin_beats_due.push_back(typed_beat);
    end
    produced = n;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (pin_beats_due.size() != 0) @(posedge clk);
    // beats that produce nothing may still be in flight in the pipeline
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_cycle(input logic wr, input reg_idx_t idx, input logic [31:0] wdata,
                           output logic [31:0] rdata);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = wr;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic check_reg(input reg_idx_t idx);
    logic [31:0] got;
    apb_cycle(1'b0, idx, 32'h0, got);
    if (idx == REG_ADDR_BITS) check_field("address_bits", 32'(addr_bits_shadow), got);
    else                      check_field("poll_limit", 32'(poll_limit_shadow), got);
  endtask

  task automatic set_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] ignored;
    drain_results();
    apb_cycle(1'b1, idx, value, ignored);
    if (idx == REG_ADDR_BITS) addr_bits_shadow = value[3:0];
    else                      poll_limit_shadow = value[13:0];
    check_reg(idx);
  endtask

  initial begin
    in_item_t it;
    int       n;
    int       busy_items;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    fail_count     = 0;
    send_idle_pct  = 25;
    recv_stall_pct = 76;
    mdl_frame      = '0;
    mdl_bits_left  = '0;
    mdl_capture    = '0;
    mdl_mode       = MODE_IDLE;
    mdl_polls      = '0;
    addr_bits_shadow  = ADDR_BITS_RESET;
    poll_limit_shadow = POLL_LIMIT_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    check_reg(REG_ADDR_BITS);
    check_reg(REG_POLL_LIMIT);

    foreach (directed_plan[r]) begin
      case (directed_plan[r].kind)
        ROW_SET_ADDR_BITS:  set_reg(REG_ADDR_BITS, 32'(directed_plan[r].wdata));
        ROW_SET_POLL_LIMIT: set_reg(REG_POLL_LIMIT, 32'(directed_plan[r].wdata));
        default: begin
          for (int k = 0; k < directed_plan[r].reps; k++) begin
            it.cmd   = directed_plan[r].cmd;
            it.addr  = directed_plan[r].addr;
            it.wdata = directed_plan[r].wdata;
            it.level = (directed_plan[r].lvl == LVL_ALT) ? k[0]
                                                         : (directed_plan[r].lvl == LVL_HIGH);
            send_item(it, directed_plan[r].typed_n, directed_plan[r].typed_beat, n);
          end
        end
      endcase
    end

    for (int p = 0; p < 3; p++) begin
      send_idle_pct  = (p == 0) ? 25 : (p == 1) ? 76 : 0;
      recv_stall_pct = (p == 0) ? 76 : (p == 1) ? 25 : 0;
      for (int s = 0; s < 2; s++) begin
        set_reg(REG_ADDR_BITS, 32'(SEG_ADDR_BITS[2*p+s]));
        set_reg(REG_POLL_LIMIT, 32'(SEG_POLL_LIMIT[2*p+s]));
        busy_items = 0;
        while (busy_items < ITEMS_PER_SEG) begin
          it = pick_item();
          send_item(it, PREDICT, NO_BEAT, n);
          if (n > 0) busy_items++;
        end
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("microwire_eeprom_master regression: pass");
    end else begin
      $display("microwire_eeprom_master regression: fail");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("microwire_eeprom_master regression: fail");
    $finish;
  end

endmodule

[microwire_eeprom_master.f]
design/mwee_pkg.sv
design/microwire_eeprom_master.sv
dv/microwire_eeprom_master_tb.sv
